@@ sv/jetp_pkg.sv @@
// ----------------------------------------------------------------------------
// jetp_pkg: shared types and constants for the Julia escape-time pixel block
// Holds register reset values, register indexes, widths, the start point, state enums and sat32.
// ----------------------------------------------------------------------------
package jetp_pkg;

   localparam int unsigned PIX_W = 10;
   localparam int unsigned CNT_W = 10;
   localparam int unsigned FRAC_BITS = 28;
   localparam int unsigned DEF_SCREEN_WIDTH = 1024;
   localparam int unsigned DEF_SCREEN_HEIGHT = 1024;

   localparam logic [2:0] REG_X_LEFT = 3'd0;
   localparam logic [2:0] REG_X_RIGHT = 3'd1;
   localparam logic [2:0] REG_Y_TOP = 3'd2;
   localparam logic [2:0] REG_Y_BOTTOM = 3'd3;
   localparam logic [2:0] REG_C_REAL = 3'd4;
   localparam logic [2:0] REG_C_IMAG = 3'd5;
   localparam logic [2:0] REG_ITER_LIMIT = 3'd6;

   localparam logic signed [31:0] RST_X_LEFT = -32'sd858993459;
   localparam logic signed [31:0] RST_X_RIGHT = 32'sd858993459;
   localparam logic signed [31:0] RST_Y_TOP = -32'sd536870912;
   localparam logic signed [31:0] RST_Y_BOTTOM = 32'sd536870912;
   localparam logic signed [30:0] RST_C_REAL = 31'sd76504105;
   localparam logic signed [30:0] RST_C_IMAG = 31'sd2684355;
   localparam logic [CNT_W-1:0] RST_ITER_LIMIT = 10'd36;

   // Start point handed from the front end to the iteration engine.
   typedef struct packed {
      logic signed [31:0] zr;
      logic signed [31:0] zi;
   } start_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQR,
      ST_SQI,
      ST_UPD,
      ST_MUL,
      ST_DONE
   } iter_state_type;

   typedef enum logic [2:0] {
      MP_IDLE,
      MP_PROD,
      MP_ACC,
      MP_FIN,
      MP_ADD,
      MP_PUSH
   } map_state_type;

   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      if (v > 48'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -48'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage

@@ sv/jetp_map.sv @@
// ----------------------------------------------------------------------------
// jetp_map: front end
// Accepts a pixel and maps it into the complex window, one axis after the other.
// ----------------------------------------------------------------------------
module jetp_map #(
   parameter int unsigned SCREEN_WIDTH = jetp_pkg::DEF_SCREEN_WIDTH,
   parameter int unsigned SCREEN_HEIGHT = jetp_pkg::DEF_SCREEN_HEIGHT
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic [jetp_pkg::PIX_W-1:0] pixel_x,
   input  logic [jetp_pkg::PIX_W-1:0] pixel_y,
   input  logic signed [31:0] x_left,
   input  logic signed [31:0] x_right,
   input  logic signed [31:0] y_top,
   input  logic signed [31:0] y_bottom,
   output logic q_push,
   input  logic q_full,
   output jetp_pkg::start_type q_data
);
   // Division by the screen size is done by a reciprocal multiply plus one
   // correction step; the quotient magnitude fits in 43 bits. The wide
   // reciprocal product is built from four 22x22 partial products, one per
   // cycle, so each axis runs a product step, an accumulate step per partial
   // product, a correction step and a final add.
   localparam int unsigned RSH = 44;
   localparam int unsigned HALF = 22;
   localparam logic [43:0] RECW = 44'(((64'd1 << RSH) / SCREEN_WIDTH) + 64'd1);
   localparam logic [43:0] RECH = 44'(((64'd1 << RSH) / SCREEN_HEIGHT) + 64'd1);

   jetp_pkg::map_state_type st_ff, st_in;
   logic ax_ff, ax_in;
   logic [1:0] ph_ff, ph_in;
   logic neg_ff, neg_in;
   logic [jetp_pkg::PIX_W-1:0] px_ff, px_in;
   logic [jetp_pkg::PIX_W-1:0] py_ff, py_in;
   logic [42:0] prod_ff, prod_in;
   logic [86:0] acc_ff, acc_in;
   logic [42:0] quo_ff, quo_in;
   logic signed [31:0] zr_ff, zr_in;
   logic signed [31:0] zi_ff, zi_in;

   logic [jetp_pkg::PIX_W-1:0] pix;
   logic signed [31:0] lo, hi;
   logic signed [32:0] diff;
   logic [32:0] mag;
   logic [42:0] prod;
   logic [43:0] rec;
   logic [21:0] mul_a, mul_b;
   logic [43:0] pp;
   logic [86:0] pp_sh;
   logic [42:0] quo;
   logic [43:0] rem;
   logic [12:0] size;
   logic signed [44:0] sq;
   logic signed [31:0] res;

   always_comb begin
      if (ax_ff) begin
         lo = y_top;
         hi = y_bottom;
         size = 13'(SCREEN_HEIGHT);
         rec = RECH;
         pix = py_ff;
      end else begin
         lo = x_left;
         hi = x_right;
         size = 13'(SCREEN_WIDTH);
         rec = RECW;
         pix = px_ff;
      end
      diff = 33'(hi) - 33'(lo);
      mag = diff[32] ? 33'(-diff) : 33'(diff);
      prod = 43'(pix) * 43'(mag);
      mul_a = ph_ff[1] ? 22'(prod_ff[42:HALF]) : prod_ff[HALF-1:0];
      mul_b = ph_ff[0] ? rec[43:HALF] : rec[HALF-1:0];
      pp = 44'(mul_a) * 44'(mul_b);
      case (ph_ff)
         2'd0: pp_sh = 87'(pp);
         2'd3: pp_sh = 87'(pp) << (2 * HALF);
         default: pp_sh = 87'(pp) << HALF;
      endcase
      quo = acc_ff[RSH +: 43];
      rem = 44'(prod_ff) - 44'(quo) * 44'(size);
      sq = neg_ff ? -45'(quo_ff) : 45'(quo_ff);
      res = jetp_pkg::sat32(48'(sq) + 48'(lo));
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         jetp_pkg::MP_IDLE: if (push) st_in = jetp_pkg::MP_PROD;
         jetp_pkg::MP_PROD: st_in = jetp_pkg::MP_ACC;
         jetp_pkg::MP_ACC: if (ph_ff == 2'd3) st_in = jetp_pkg::MP_FIN;
         jetp_pkg::MP_FIN: st_in = jetp_pkg::MP_ADD;
         jetp_pkg::MP_ADD: st_in = ax_ff ? jetp_pkg::MP_PUSH : jetp_pkg::MP_PROD;
         jetp_pkg::MP_PUSH: if (!q_full) st_in = jetp_pkg::MP_IDLE;
         default: st_in = jetp_pkg::MP_IDLE;
      endcase
   end

   // Both pixel fields are captured at the accept edge; the caller need not
   // hold them afterwards.
   always_comb begin
      ax_in = ax_ff;
      ph_in = ph_ff;
      neg_in = neg_ff;
      px_in = px_ff;
      py_in = py_ff;
      prod_in = prod_ff;
      acc_in = acc_ff;
      quo_in = quo_ff;
      zr_in = zr_ff;
      zi_in = zi_ff;
      full = (st_ff != jetp_pkg::MP_IDLE);
      q_push = (st_ff == jetp_pkg::MP_PUSH) && !q_full;
      q_data.zr = zr_ff;
      q_data.zi = zi_ff;
      case (st_ff)
         jetp_pkg::MP_IDLE: begin
            px_in = pixel_x;
            py_in = pixel_y;
            ax_in = 1'b0;
         end
         jetp_pkg::MP_PROD: begin
            prod_in = prod;
            neg_in = diff[32];
            acc_in = '0;
            ph_in = 2'd0;
         end
         jetp_pkg::MP_ACC: begin
            acc_in = acc_ff + pp_sh;
            ph_in = ph_ff + 2'd1;
         end
         jetp_pkg::MP_FIN: quo_in = rem[43] ? quo - 43'd1 : quo;
         jetp_pkg::MP_ADD: begin
            if (ax_ff) begin
               zi_in = res;
            end else begin
               zr_in = res;
               ax_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= jetp_pkg::MP_IDLE;
      end else begin
         st_ff <= st_in;
      end
      ax_ff <= ax_in;
      ph_ff <= ph_in;
      neg_ff <= neg_in;
      px_ff <= px_in;
      py_ff <= py_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      quo_ff <= quo_in;
      zr_ff <= zr_in;
      zi_ff <= zi_in;
   end
endmodule

@@ sv/jetp_fifo.sv @@
// ----------------------------------------------------------------------------
// jetp_fifo: small queue
// A two-entry register queue, used for the start points and for the results.
// ----------------------------------------------------------------------------
module jetp_fifo #(
   parameter int unsigned WIDTH = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic [WIDTH-1:0] wdata,
   input  logic pop,
   output logic empty,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [2];
   logic wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign rdata = mem_ff[rp_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign wp_in = do_push ? !wp_ff : wp_ff;
   assign rp_in = do_pop ? !rp_ff : rp_ff;
   assign cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wp_ff] <= wdata;
      end
   end
endmodule

@@ sv/jetp_iter.sv @@
// ----------------------------------------------------------------------------
// jetp_iter: back end
// Iterates the map with one shared 32x32 multiplier through SQR, SQI, UPD and MUL.
// ----------------------------------------------------------------------------
module jetp_iter (
   input  logic clock,
   input  logic reset,
   input  logic q_empty,
   output logic q_pop,
   input  jetp_pkg::start_type q_data,
   input  logic signed [30:0] c_real,
   input  logic signed [30:0] c_imag,
   input  logic [jetp_pkg::CNT_W-1:0] iteration_limit,
   output logic r_push,
   input  logic r_full,
   output logic [jetp_pkg::CNT_W-1:0] r_count
);
   jetp_pkg::iter_state_type st_ff, st_in;
   logic signed [31:0] zr_ff, zr_in, zi_ff, zi_in;
   logic signed [35:0] zr2_ff, zr2_in, zi2_ff, zi2_in;
   logic [jetp_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic signed [31:0] ma, mb;
   logic signed [63:0] mp;
   logic in_bound;
   logic [jetp_pkg::CNT_W:0] cnt_nx;

   assign mp = ma * mb;
   assign in_bound = (37'(zr2_ff) + 37'(zi2_ff)) < 37'sd1073741824;
   assign cnt_nx = 11'(cnt_ff) + 11'd1;

   always_comb begin
      ma = zr_ff;
      mb = zr_ff;
      if (st_ff == jetp_pkg::ST_SQI) begin
         ma = zi_ff;
         mb = zi_ff;
      end else if (st_ff == jetp_pkg::ST_MUL) begin
         ma = zi_ff;
         mb = zr_ff;
      end
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         jetp_pkg::ST_IDLE: if (!q_empty) st_in = jetp_pkg::ST_SQR;
         jetp_pkg::ST_SQR: st_in = jetp_pkg::ST_SQI;
         jetp_pkg::ST_SQI: st_in = jetp_pkg::ST_UPD;
         jetp_pkg::ST_UPD: st_in = jetp_pkg::ST_MUL;
         jetp_pkg::ST_MUL: begin
            if (!in_bound || cnt_nx >= 11'(iteration_limit)) st_in = jetp_pkg::ST_DONE;
            else st_in = jetp_pkg::ST_SQR;
         end
         jetp_pkg::ST_DONE: if (!r_full) st_in = jetp_pkg::ST_IDLE;
         default: st_in = jetp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      zr_in = zr_ff;
      zi_in = zi_ff;
      zr2_in = zr2_ff;
      zi2_in = zi2_ff;
      cnt_in = cnt_ff;
      q_pop = (st_ff == jetp_pkg::ST_IDLE) && !q_empty;
      r_push = (st_ff == jetp_pkg::ST_DONE) && !r_full;
      r_count = cnt_ff;
      case (st_ff)
         jetp_pkg::ST_IDLE: begin
            zr_in = q_data.zr;
            zi_in = q_data.zi;
            cnt_in = '0;
         end
         jetp_pkg::ST_SQR: zr2_in = 36'(mp >>> jetp_pkg::FRAC_BITS);
         jetp_pkg::ST_SQI: zi2_in = 36'(mp >>> jetp_pkg::FRAC_BITS);
         jetp_pkg::ST_UPD: zr_in = jetp_pkg::sat32(48'(zr2_ff) - 48'(zi2_ff) + 48'(c_real));
         jetp_pkg::ST_MUL: begin
            zi_in = jetp_pkg::sat32(48'(mp >>> (jetp_pkg::FRAC_BITS - 1)) + 48'(c_imag));
            if (in_bound) cnt_in = cnt_nx[jetp_pkg::CNT_W-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= jetp_pkg::ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
      zr_ff <= zr_in;
      zi_ff <= zi_in;
      zr2_ff <= zr2_in;
      zi2_ff <= zi2_in;
      cnt_ff <= cnt_in;
   end
endmodule

@@ sv/julia_escape_time_pixel.sv @@
// ----------------------------------------------------------------------------
// julia_escape_time_pixel: Julia set escape-time evaluator for one pixel
// Maps a pixel into a complex window and counts iterations until escape or the limit.
// ----------------------------------------------------------------------------
// A pixel transaction is mapped by the front end, one axis after the other
// with a reciprocal division each, plus the hand-off, during which full stays
// high, and then queued. The back end runs each iteration on one shared
// 32x32 multiplier as two squares, the real update and the cross product,
// and a pixel runs N iterations there, where N is its escape count plus one,
// at most iteration_limit (one when the limit is zero). Results wait in a
// two-entry queue, so work goes on while the consumer stalls, until it fills.
// Configuration must be written only while the block is idle; writes to
// unknown indexes are ignored.
module julia_escape_time_pixel #(
   parameter int unsigned SCREEN_WIDTH = jetp_pkg::DEF_SCREEN_WIDTH,
   parameter int unsigned SCREEN_HEIGHT = jetp_pkg::DEF_SCREEN_HEIGHT
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic [jetp_pkg::PIX_W-1:0] req_pixel_x,
   input  logic [jetp_pkg::PIX_W-1:0] req_pixel_y,
   output logic empty,
   input  logic pop,
   output logic [jetp_pkg::CNT_W-1:0] rsp_escape_count,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [2:0] csr_index,
   input  logic [31:0] csr_data
);
   logic signed [31:0] xl_ff, xr_ff, yt_ff, yb_ff;
   logic signed [30:0] cr_ff, ci_ff;
   logic [jetp_pkg::CNT_W-1:0] lim_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         xl_ff <= jetp_pkg::RST_X_LEFT;
         xr_ff <= jetp_pkg::RST_X_RIGHT;
         yt_ff <= jetp_pkg::RST_Y_TOP;
         yb_ff <= jetp_pkg::RST_Y_BOTTOM;
         cr_ff <= jetp_pkg::RST_C_REAL;
         ci_ff <= jetp_pkg::RST_C_IMAG;
         lim_ff <= jetp_pkg::RST_ITER_LIMIT;
      end else if (csr_valid) begin
         case (csr_index)
            jetp_pkg::REG_X_LEFT: xl_ff <= csr_data;
            jetp_pkg::REG_X_RIGHT: xr_ff <= csr_data;
            jetp_pkg::REG_Y_TOP: yt_ff <= csr_data;
            jetp_pkg::REG_Y_BOTTOM: yb_ff <= csr_data;
            jetp_pkg::REG_C_REAL: cr_ff <= csr_data[30:0];
            jetp_pkg::REG_C_IMAG: ci_ff <= csr_data[30:0];
            jetp_pkg::REG_ITER_LIMIT: lim_ff <= csr_data[jetp_pkg::CNT_W-1:0];
            default: ;
         endcase
      end
   end

   logic sq_push, sq_full, sq_pop, sq_empty;
   jetp_pkg::start_type sq_wdata, sq_rdata;
   logic r_push, r_full;
   logic [jetp_pkg::CNT_W-1:0] r_count;

   jetp_map #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_map (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .pixel_x(req_pixel_x), .pixel_y(req_pixel_y),
      .x_left(xl_ff), .x_right(xr_ff), .y_top(yt_ff), .y_bottom(yb_ff),
      .q_push(sq_push), .q_full(sq_full), .q_data(sq_wdata)
   );

   jetp_fifo #(.WIDTH($bits(jetp_pkg::start_type))) u_sq (
      .clock(clock), .reset(reset), .push(sq_push), .full(sq_full),
      .wdata(sq_wdata), .pop(sq_pop), .empty(sq_empty), .rdata(sq_rdata)
   );

   jetp_iter u_iter (
      .clock(clock), .reset(reset), .q_empty(sq_empty), .q_pop(sq_pop),
      .q_data(sq_rdata), .c_real(cr_ff), .c_imag(ci_ff),
      .iteration_limit(lim_ff), .r_push(r_push), .r_full(r_full), .r_count(r_count)
   );

   jetp_fifo #(.WIDTH(jetp_pkg::CNT_W)) u_rq (
      .clock(clock), .reset(reset), .push(r_push), .full(r_full),
      .wdata(r_count), .pop(pop), .empty(empty), .rdata(rsp_escape_count)
   );
endmodule

@@ bench/tb_julia_escape_time_pixel.sv @@
// ----------------------------------------------------------------------------
// tb_julia_escape_time_pixel: self-checking bench for the Julia escape pixel
// Drives pixel transactions through the queue ports, predicts each escape
// count in fixed point and compares it with the returned count, in order.
// ----------------------------------------------------------------------------
module tb_julia_escape_time_pixel;

   // The block is built with its default screen size.
   localparam longint SCR_W = jetp_pkg::DEF_SCREEN_WIDTH;
   localparam longint SCR_H = jetp_pkg::DEF_SCREEN_HEIGHT;
   localparam longint ESC_BOUND = longint'(4) <<< jetp_pkg::FRAC_BITS;

   logic clock;
   logic reset;
   logic push;
   logic full;
   logic [jetp_pkg::PIX_W-1:0] req_pixel_x;
   logic [jetp_pkg::PIX_W-1:0] req_pixel_y;
   logic empty;
   logic pop;
   logic [jetp_pkg::CNT_W-1:0] rsp_escape_count;
   logic csr_valid;
   logic csr_ready;
   logic [2:0] csr_index;
   logic [31:0] csr_data;

   julia_escape_time_pixel dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_pixel_x(req_pixel_x),
      .req_pixel_y(req_pixel_y),
      .empty(empty),
      .pop(pop),
      .rsp_escape_count(rsp_escape_count),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Bench copy of the window, the Julia constant and the iteration cap.
   longint win_x_left;
   longint win_x_right;
   longint win_y_top;
   longint win_y_bottom;
   longint julia_cr;
   longint julia_ci;
   int unsigned iter_cap;

   int unsigned expected_counts[$];
   int error_count;
   // When set, the receiver stops popping so that the block backs up.
   bit hold_results;
   bit draining_quiet;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Generous limit: several times the longest possible run, with every pixel
   // at its cap and the longest gaps on both sides.
   initial begin
      #150_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) begin
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // Arithmetic shift right rounds toward minus infinity, as required.
   function automatic longint floor_div_pow2(input longint v, input int k);
      return v >>> k;
   endfunction

   function automatic longint window_start(input longint pix, input longint lo,
                                           input longint hi, input longint size);
      longint prod;
      prod = pix * (hi - lo);
      // SystemVerilog division of signed integers truncates toward zero.
      return clamp32(prod / size + lo);
   endfunction

   function automatic int unsigned escape_count_of(input int unsigned px,
                                                   input int unsigned py);
      longint zr;
      longint zi;
      longint zr2;
      longint zi2;
      int unsigned count;
      zr = window_start(px, win_x_left, win_x_right, SCR_W);
      zi = window_start(py, win_y_top, win_y_bottom, SCR_H);
      count = 0;
      forever begin
         zr2 = floor_div_pow2(zr * zr, jetp_pkg::FRAC_BITS);
         zi2 = floor_div_pow2(zi * zi, jetp_pkg::FRAC_BITS);
         zr = clamp32(zr2 - zi2 + julia_cr);
         zi = clamp32(floor_div_pow2(zi * zr, jetp_pkg::FRAC_BITS - 1) + julia_ci);
         // The escape test looks at the squares from before the update.
         if (zr2 + zi2 >= ESC_BOUND) begin
            break;
         end
         count++;
         if (count >= iter_cap) begin
            break;
         end
      end
      return count & 10'h3FF;
   endfunction

   task automatic load_reset_values();
      win_x_left = jetp_pkg::RST_X_LEFT;
      win_x_right = jetp_pkg::RST_X_RIGHT;
      win_y_top = jetp_pkg::RST_Y_TOP;
      win_y_bottom = jetp_pkg::RST_Y_BOTTOM;
      julia_cr = jetp_pkg::RST_C_REAL;
      julia_ci = jetp_pkg::RST_C_IMAG;
      iter_cap = jetp_pkg::RST_ITER_LIMIT;
   endtask

   // Writes one register and mirrors the write into the prediction state.
   // The channel goes idle after each write.
   task automatic write_csr(input logic [2:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      case (idx)
         jetp_pkg::REG_X_LEFT: win_x_left = longint'($signed(value));
         jetp_pkg::REG_X_RIGHT: win_x_right = longint'($signed(value));
         jetp_pkg::REG_Y_TOP: win_y_top = longint'($signed(value));
         jetp_pkg::REG_Y_BOTTOM: win_y_bottom = longint'($signed(value));
         jetp_pkg::REG_C_REAL: julia_cr = longint'($signed(value[30:0]));
         jetp_pkg::REG_C_IMAG: julia_ci = longint'($signed(value[30:0]));
         jetp_pkg::REG_ITER_LIMIT: iter_cap = value[9:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Sends one pixel transaction after a random gap and records its count.
   // Push is left high after the accept edge; a later call that waits a gap,
   // or wait_idle, takes it down.
   task automatic send_pixel(input int unsigned px, input int unsigned py);
      int unsigned gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_pixel_x <= px[jetp_pkg::PIX_W-1:0];
      req_pixel_y <= py[jetp_pkg::PIX_W-1:0];
      @(posedge clock);
      while (full) begin
         @(posedge clock);
      end
      expected_counts.push_back(escape_count_of(px, py));
   endtask

   // Waits until every count is back, then lets the back end settle.
   task automatic wait_idle();
      int unsigned guard;
      guard = 0;
      push <= 1'b0;
      while (expected_counts.size() != 0 && guard < 2_000_000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
   endtask

   // Result side: random pop gaps, and a hold-off when requested.
   initial begin
      int unsigned stall;
      pop = 1'b0;
      forever begin
         @(posedge clock);
         if (pop && !empty) begin
            if (expected_counts.size() == 0) begin
               $display("%0t: unexpected count %0d", $time, rsp_escape_count);
               error_count++;
            end else begin
               if (rsp_escape_count !== expected_counts[0][jetp_pkg::CNT_W-1:0]) begin
                  $display("%0t: escape_count expected %0d actual %0d", $time,
                           expected_counts[0], rsp_escape_count);
                  error_count++;
               end
               void'(expected_counts.pop_front());
            end
            stall = draining_quiet ? 0 : $urandom_range(0, 17);
            if (stall != 0) begin
               pop <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            pop <= !hold_results;
         end else begin
            pop <= !hold_results;
         end
      end
   end

   task automatic test_reset_defaults();
      send_pixel(0, 0);
      send_pixel(1023, 1023);
      send_pixel(512, 512);
      send_pixel(1023, 0);
      send_pixel(0, 1023);
      send_pixel(341, 682);
      wait_idle();
   endtask

   task automatic test_field_extremes();
      int unsigned b;
      // A walking one on x and a walking zero on y reach every bit of both pixel fields.
      for (b = 0; b < jetp_pkg::PIX_W; b++) begin
         send_pixel(1 << b, (1 << (jetp_pkg::PIX_W - 1 - b)) ^ 10'h3FF);
      end
      wait_idle();
   endtask

   task automatic test_corner_registers();
      // Widest window puts start values at the ends of the range; cap zero; reversed edges.
      write_csr(jetp_pkg::REG_X_LEFT, 32'h8000_0000);
      write_csr(jetp_pkg::REG_X_RIGHT, 32'h7FFF_FFFF);
      write_csr(jetp_pkg::REG_Y_TOP, 32'h7FFF_FFFF);
      write_csr(jetp_pkg::REG_Y_BOTTOM, 32'h8000_0000);
      write_csr(jetp_pkg::REG_C_REAL, 32'h2000_0000);
      write_csr(jetp_pkg::REG_C_IMAG, 32'h6000_0000);
      write_csr(jetp_pkg::REG_ITER_LIMIT, 32'h0000_0000);
      send_pixel(0, 0);
      send_pixel(512, 512);
      send_pixel(1023, 1023);
      wait_idle();
      write_csr(jetp_pkg::REG_ITER_LIMIT, 32'h0000_0001);
      write_csr(jetp_pkg::REG_C_REAL, 32'h6000_0000);
      write_csr(jetp_pkg::REG_C_IMAG, 32'h2000_0000);
      send_pixel(512, 511);
      send_pixel(0, 1023);
      wait_idle();
      // An unknown index should leave every register alone; all are rewritten after it.
      write_csr(3'd7, 32'hDEAD_BEEF);
      write_csr(jetp_pkg::REG_ITER_LIMIT, 32'h0000_03FF);
      write_csr(jetp_pkg::REG_X_LEFT, 32'h0000_0000);
      write_csr(jetp_pkg::REG_X_RIGHT, 32'h0000_0000);
      write_csr(jetp_pkg::REG_Y_TOP, 32'h0000_0000);
      write_csr(jetp_pkg::REG_Y_BOTTOM, 32'h0000_0000);
      write_csr(jetp_pkg::REG_C_REAL, 32'h0000_0000);
      write_csr(jetp_pkg::REG_C_IMAG, 32'h0000_0000);
      // The origin is a fixed point, so this pixel runs to the full cap.
      send_pixel(17, 900);
      wait_idle();
   endtask

   task automatic random_config();
      int unsigned r;
      r = $urandom_range(0, 3);
      write_csr(jetp_pkg::REG_X_LEFT,
                -32'sd858993459 + $signed($urandom_range(0, 1 << 26)));
      write_csr(jetp_pkg::REG_X_RIGHT, r == 0 ? $urandom : 32'd858993459);
      write_csr(jetp_pkg::REG_Y_TOP, r == 1 ? $urandom : -32'sd536870912);
      write_csr(jetp_pkg::REG_Y_BOTTOM, 32'd536870912 - $urandom_range(0, 1 << 27));
      write_csr(jetp_pkg::REG_C_REAL, $urandom);
      write_csr(jetp_pkg::REG_C_IMAG, $urandom);
      write_csr(jetp_pkg::REG_ITER_LIMIT, $urandom_range(0, 3) == 0 ? 32'h0 :
                $urandom_range(1, 40));
   endtask

   task automatic test_random_pixels();
      int unsigned phase;
      int unsigned k;
      for (phase = 0; phase < 13; phase++) begin
         random_config();
         for (k = 0; k < 48; k++) begin
            send_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
         end
         wait_idle();
      end
   endtask

   task automatic test_backpressure();
      int unsigned k;
      write_csr(jetp_pkg::REG_ITER_LIMIT, 32'd3);
      hold_results = 1'b1;
      // The receiver holds off for a long stretch while pixels keep coming.
      fork
         begin
            repeat (400) @(posedge clock);
            hold_results = 1'b0;
         end
         begin
            for (k = 0; k < 20; k++) begin
               send_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
            end
         end
      join
      wait_idle();
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      push = 1'b0;
      req_pixel_x = '0;
      req_pixel_y = '0;
      csr_valid = 1'b0;
      csr_index = jetp_pkg::REG_X_LEFT;
      csr_data = '0;
      error_count = 0;
      hold_results = 1'b0;
      draining_quiet = 1'b0;
      load_reset_values();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_field_extremes();
      test_corner_registers();
      test_random_pixels();
      test_backpressure();
      draining_quiet = 1'b1;
      wait_idle();
      repeat (4500) @(posedge clock);
      if (error_count == 0 && expected_counts.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ julia_escape_time_pixel.f @@
sv/jetp_pkg.sv
sv/jetp_map.sv
sv/jetp_fifo.sv
sv/jetp_iter.sv
sv/julia_escape_time_pixel.sv
bench/tb_julia_escape_time_pixel.sv
